@@ rtl/sdtc_pkg.sv @@
`default_nettype none

package sdtc_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int THRESH_W     = 11;
    localparam int MAG_W        = 11;
    localparam int CLASS_W      = 2;
    localparam int EMIT_W       = 22;
    localparam int TOTAL_W      = WIDTH_W + HEIGHT_W;
    localparam int SIDE_W       = PIXEL_BITS + 2;
    localparam int SUM_W        = 2 * SIDE_W + 1;
    localparam int ROOT_W       = SUM_W + 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH   = 2'd3;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

    typedef struct packed {
        logic             need_root;
        logic [SUM_W-1:0] sum;
        logic             last;
    } sdtc_job_t;

endpackage

`default_nettype wire

@@ rtl/sdtc_fifo.sv @@
`default_nettype none

module sdtc_fifo
    import sdtc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire sdtc_job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output sdtc_job_t      pop_job,
    output logic           empty
);

    sdtc_job_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]      count_reg, count_next;
    logic                     do_push, do_pop;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_job  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sdtc_front.sv @@
`default_nettype none

module sdtc_front
    import sdtc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  opcode,
    input  wire logic [PIXEL_BITS-1:0] gray,
    input  wire logic [WIDTH_W-1:0]    image_width,
    input  wire logic [HEIGHT_W-1:0]   image_height,
    output logic                       push,
    output sdtc_job_t                  push_job,
    input  wire logic                  full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_WIN  = 4'b0010,
        F_GRAD = 4'b0100,
        F_SQ   = 4'b1000
    } front_state_t;

    front_state_t               state_reg, state_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [EMIT_W-1:0]          emit_reg, emit_next;
    logic                       done_reg, done_next;
    logic [COL_W-1:0]           addr_reg;
    logic [PIXEL_BITS-1:0]      pix_reg;
    logic                       emit_flag_reg, need_reg;
    logic [PIXEL_BITS-1:0]      upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]      middle_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0]      top_q, mid_q;
    logic [PIXEL_BITS-1:0]      win_reg [3][3];
    logic [SIDE_W-1:0]          ax_reg, ay_reg;

    logic [WIDTH_W-1:0]         w_eff;
    logic [HEIGHT_W-1:0]        h_eff;
    logic [TOTAL_W-1:0]         total;
    logic [COL_W-1:0]           c_cur;
    logic [ROW_W-1:0]           r_cur;
    logic                       accept, last_hit, pix_emit, pix_need;
    logic [SIDE_W-1:0]          gx_pos, gx_neg, gy_pos, gy_neg;

    always_comb
    begin
        if (image_width < WIDTH_W'(3))
            w_eff = WIDTH_W'(3);
        else if (image_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = image_width;
        if (image_height < HEIGHT_W'(3))
            h_eff = HEIGHT_W'(3);
        else if (image_height > HEIGHT_W'(HEIGHT_LIMIT))
            h_eff = HEIGHT_W'(HEIGHT_LIMIT);
        else
            h_eff = image_height;
    end

    assign total = TOTAL_W'(w_eff) * TOTAL_W'(h_eff);
    assign c_cur = ({1'b0, col_reg} >= w_eff) ? COL_W'(w_eff - 1'b1) : col_reg;
    assign r_cur = ({1'b0, row_reg} >= h_eff) ? ROW_W'(h_eff - 1'b1) : row_reg;
    assign pix_emit = (r_cur >= ROW_W'(2)) || (r_cur == ROW_W'(1) && c_cur >= COL_W'(1));
    assign pix_need = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
    assign last_hit = (TOTAL_W'(emit_reg) + 1'b1) >= total;

    assign in_ready = (state_reg == F_IDLE) && !full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        gx_pos = SIDE_W'(win_reg[0][2]) + {1'b0, win_reg[1][2], 1'b0} + SIDE_W'(win_reg[2][2]);
        gx_neg = SIDE_W'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0} + SIDE_W'(win_reg[2][0]);
        gy_pos = SIDE_W'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0} + SIDE_W'(win_reg[2][2]);
        gy_neg = SIDE_W'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0} + SIDE_W'(win_reg[0][2]);
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        emit_next  = emit_reg;
        done_next  = done_reg;
        push       = 1'b0;
        push_job   = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (done_reg)
                    begin
                        push          = 1'b1;
                        push_job.last = last_hit;
                        if (last_hit)
                        begin
                            col_next  = '0;
                            row_next  = '0;
                            emit_next = '0;
                            done_next = 1'b0;
                        end
                        else
                        begin
                            emit_next = emit_reg + 1'b1;
                        end
                    end
                    else if (opcode == OP_PIXEL)
                    begin
                        state_next = F_WIN;
                        if (pix_emit)
                            emit_next = emit_reg + 1'b1;
                        if ((WIDTH_W'(c_cur) + 1'b1) >= w_eff)
                        begin
                            col_next = '0;
                            row_next = r_cur;
                            if ((HEIGHT_W'(r_cur) + 1'b1) >= h_eff)
                                done_next = 1'b1;
                            else
                                row_next = r_cur + 1'b1;
                        end
                        else
                        begin
                            col_next = c_cur + 1'b1;
                            row_next = r_cur;
                        end
                    end
                end
            end
            F_WIN:
            begin
                state_next = emit_flag_reg ? F_GRAD : F_IDLE;
            end
            F_GRAD:
            begin
                state_next = F_SQ;
            end
            F_SQ:
            begin
                push               = 1'b1;
                push_job.need_root = need_reg;
                push_job.sum       = SUM_W'(ax_reg * ax_reg) + SUM_W'(ay_reg * ay_reg);
                state_next         = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            emit_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            emit_reg  <= emit_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg      <= c_cur;
            pix_reg       <= gray;
            emit_flag_reg <= pix_emit;
            need_reg      <= pix_need;
            top_q         <= upper_mem[c_cur];
            mid_q         <= middle_mem[c_cur];
        end
        if (state_reg == F_WIN)
        begin
            upper_mem[addr_reg]  <= mid_q;
            middle_mem[addr_reg] <= pix_reg;
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= top_q;
            win_reg[1][2] <= mid_q;
            win_reg[2][2] <= pix_reg;
        end
        if (state_reg == F_GRAD)
        begin
            ax_reg <= (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
            ay_reg <= (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sdtc_back.sv @@
`default_nettype none

module sdtc_back
    import sdtc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire sdtc_job_t           pop_job,
    output logic                     pop,
    input  wire logic [THRESH_W-1:0] low_threshold,
    input  wire logic [THRESH_W-1:0] high_threshold,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CLASS_W-1:0]       edge_class,
    output logic [MAG_W-1:0]         magnitude,
    output logic                     last_pixel
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_ROOT = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [SUM_W-1:0]     bit_reg;
    logic                 last_reg;
    logic [CLASS_W-1:0]   class_reg;
    logic [MAG_W-1:0]     mag_reg;
    logic                 last_out_reg;
    logic [ROOT_W-1:0]    trial;
    logic [MAG_W-1:0]     g;
    logic                 load_out;

    assign trial    = root_reg + ROOT_W'(bit_reg);
    assign g        = root_reg[MAG_W-1:0] + MAG_W'(ROOT_W'(rem_reg) > root_reg);
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = pop_job.need_root ? B_ROOT : B_DONE;
            end
            B_ROOT:
            begin
                if (bit_reg[0])
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg  <= pop_job.need_root ? pop_job.sum : '0;
            root_reg <= '0;
            bit_reg  <= SUM_W'(1) << (SUM_W - 1);
            last_reg <= pop_job.last;
        end
        else if (state_reg == B_ROOT)
        begin
            if (ROOT_W'(rem_reg) >= trial)
            begin
                rem_reg  <= rem_reg - SUM_W'(trial);
                root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (load_out)
        begin
            mag_reg      <= g;
            last_out_reg <= last_reg;
            if (g >= high_threshold)
                class_reg <= CLASS_STRONG;
            else if (g < low_threshold)
                class_reg <= CLASS_NONE;
            else
                class_reg <= CLASS_WEAK;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_class = class_reg;
    assign magnitude  = mag_reg;
    assign last_pixel = last_out_reg;

endmodule

`default_nettype wire

@@ rtl/sobel_double_threshold_classify.sv @@
`default_nettype none

// sobel 3x3 gradient magnitude with two-threshold edge classing
// input channel in_valid/in_ready carries opcode and gray; a pixel
// transaction feeds the raster, a flush transaction drains one result
// once the whole image is in (any transaction does then)
// output channel out_valid/out_ready carries edge_class, magnitude and
// last_pixel; results lag the pixels by one row plus one pixel
// the front takes a pixel through line store read, window shift,
// gradient and square, stopping after the shift when no result is due,
// and accepts no new transaction until it is back in idle; a drain
// transaction is queued straight from idle; the back finds the square
// root of interior pixels one bit a cycle and skips it for border or
// drain results; a 4-entry queue sits between
// cfg_we writes cfg_data to register cfg_index: width, height, low, high
// reset restores 640x480, thresholds 125/225 and starts a new image
// line stores need no clearing after reset
// a stalled receiver holds the output register; the queue then fills and
// in_ready falls

module sobel_double_threshold_classify
    import sdtc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   opcode,
    input  wire logic [PIXEL_BITS-1:0]  gray,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CLASS_W-1:0]          edge_class,
    output logic [MAG_W-1:0]            magnitude,
    output logic                        last_pixel,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0] low_reg;
    logic [THRESH_W-1:0] high_reg;

    logic      q_push, q_full, q_pop, q_empty;
    sdtc_job_t q_push_job, q_pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
            low_reg    <= THRESH_W'(125);
            high_reg   <= THRESH_W'(225);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_LOW:    low_reg    <= cfg_data[THRESH_W-1:0];
                REG_HIGH:   high_reg   <= cfg_data[THRESH_W-1:0];
                default:    ;
            endcase
        end
    end

    sdtc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .gray         (gray),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (q_push),
        .push_job     (q_push_job),
        .full         (q_full)
    );

    sdtc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    sdtc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (q_empty),
        .pop_job        (q_pop_job),
        .pop            (q_pop),
        .low_threshold  (low_reg),
        .high_threshold (high_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .edge_class     (edge_class),
        .magnitude      (magnitude),
        .last_pixel     (last_pixel)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_ready_blocks_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready)
        else $error("input ready with queue full");

endmodule

`default_nettype wire
